/* sv/slru_pkg.sv */
// Shared constants and types for the set-associative LRU cache lookup.
`default_nettype none

package slru_pkg;

    localparam int ADDR_W      = 48;
    localparam int BLOCK_SHIFT = 6;
    localparam int BLOCK_W     = ADDR_W - BLOCK_SHIFT;
    localparam int SETS        = 2048;
    localparam int SET_BITS    = $clog2(SETS);
    localparam int TAG_W       = BLOCK_W - SET_BITS;
    localparam int DEFAULT_WAYS = 16;
    localparam int MAX_WAYS    = 32;
    localparam int WAY_IDX_W   = $clog2(MAX_WAYS);
    localparam int WAY_OUT_W   = 4;
    localparam int CNT_W       = 32;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

    typedef struct packed {
        logic                 hit;
        logic                 evicted;
        logic [WAY_IDX_W-1:0] way;
    } lookup_t;

endpackage

`default_nettype wire

/* sv/slru_ram.sv */
// Generic single-port RAM with registered read data.
`default_nettype none

module slru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/slru_update.sv */
// Tag compare, victim choice and LRU rank update for one set row.
`default_nettype none

module slru_update #(
    parameter int WAYS = slru_pkg::DEFAULT_WAYS
) (
    input  wire logic [WAYS*(1+slru_pkg::TAG_W+((WAYS > 1) ? $clog2(WAYS) : 1))-1:0] row_rd,
    input  wire logic [slru_pkg::TAG_W-1:0] tag,
    output logic [WAYS*(1+slru_pkg::TAG_W+((WAYS > 1) ? $clog2(WAYS) : 1))-1:0]      row_wr,
    output slru_pkg::lookup_t               res
);

    import slru_pkg::*;

    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_OFS  = WAYS;
    localparam int RANK_OFS = WAYS + WAYS * TAG_W;

    logic                valid   [WAYS];
    logic [TAG_W-1:0]    tags    [WAYS];
    logic [RANK_W-1:0]   ranks   [WAYS];
    logic                hit;
    logic                any_inv;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    inv_way;
    logic [WAY_W-1:0]    vict_way;
    logic [WAY_W-1:0]    sel_way;
    logic [RANK_W:0]     old_age;

    always_comb
    begin
        hit      = 1'b0;
        any_inv  = 1'b0;
        hit_way  = '0;
        inv_way  = '0;
        vict_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            valid[w] = row_rd[w];
            tags[w]  = row_rd[TAG_OFS + w*TAG_W +: TAG_W];
            ranks[w] = row_rd[RANK_OFS + w*RANK_W +: RANK_W];
        end
        // Scan downward so the lowest-numbered way wins.
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid[w] && tags[w] == tag)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!valid[w])
            begin
                any_inv = 1'b1;
                inv_way = WAY_W'(w);
            end
            // In a full set the ranks form a permutation; the oldest holds WAYS-1.
            if (ranks[w] == RANK_W'(WAYS - 1))
            begin
                vict_way = WAY_W'(w);
            end
        end

        if (hit)
        begin
            sel_way = hit_way;
        end
        else if (any_inv)
        begin
            sel_way = inv_way;
        end
        else
        begin
            sel_way = vict_way;
        end

        if (!hit && any_inv)
        begin
            old_age = (RANK_W+1)'(WAYS);
        end
        else
        begin
            old_age = {1'b0, ranks[sel_way]};
        end

        for (int k = 0; k < WAYS; k++)
        begin
            if (WAY_W'(k) == sel_way)
            begin
                row_wr[k] = 1'b1;
                row_wr[TAG_OFS + k*TAG_W +: TAG_W]    = hit ? tags[k] : tag;
                row_wr[RANK_OFS + k*RANK_W +: RANK_W] = '0;
            end
            else
            begin
                row_wr[k] = valid[k];
                row_wr[TAG_OFS + k*TAG_W +: TAG_W] = tags[k];
                if (valid[k] && ({1'b0, ranks[k]} < old_age))
                begin
                    row_wr[RANK_OFS + k*RANK_W +: RANK_W] = ranks[k] + RANK_W'(1);
                end
                else
                begin
                    row_wr[RANK_OFS + k*RANK_W +: RANK_W] = ranks[k];
                end
            end
        end

        res.hit     = hit;
        res.evicted = !hit && !any_inv;
        res.way     = WAY_IDX_W'(sel_way);
    end

endmodule

`default_nettype wire

/* sv/set_assoc_lru_cache_lookup.sv */
// Top level of the set-associative LRU cache tag lookup.
//
// Access channel: access_valid / access_stall with byte_address. Each access
// produces exactly one item on the result channel (result_valid /
// result_stall) carrying hit, way_used, evicted and the saturating hit and
// miss counts including that access.
// Each set is one row of a single-port RAM (valid bits, tags and LRU ranks of
// all ways). An access is taken in the idle cycle, which issues the row read;
// ST_LOOK then compares, updates and writes the row back and loads the
// result register. The shared RAM port (read then write-back) keeps the
// block from taking a new access before the last one is written back.
// After reset the block sweeps the RAM clearing one set per cycle with
// access_stall high; counters reset to zero. A new access may be taken
// while a result waits; if result_stall holds the result, the update of
// the next access waits until the result register frees, so nothing is
// lost.
`default_nettype none

module set_assoc_lru_cache_lookup #(
    parameter int WAYS = slru_pkg::DEFAULT_WAYS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        access_valid,
    output logic                             access_stall,
    input  wire logic [slru_pkg::ADDR_W-1:0] byte_address,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic                             hit,
    output logic [slru_pkg::WAY_OUT_W-1:0]   way_used,
    output logic                             evicted,
    output logic [slru_pkg::CNT_W-1:0]       hit_count,
    output logic [slru_pkg::CNT_W-1:0]       miss_count
);

    import slru_pkg::*;

    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W  = WAYS * (1 + TAG_W + RANK_W);

    state_t               state_reg, state_next;
    logic [SET_BITS-1:0]  clr_reg, clr_next;
    logic [SET_BITS-1:0]  set_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic                 rv_reg, rv_next;
    logic                 hit_reg;
    logic                 evicted_reg;
    logic [WAY_OUT_W-1:0] way_reg;
    logic [CNT_W-1:0]     hits_reg, hits_next;
    logic [CNT_W-1:0]     misses_reg, misses_next;

    logic                 ram_we;
    logic                 ram_re;
    logic [SET_BITS-1:0]  ram_addr;
    logic [ROW_W-1:0]     ram_wdata;
    logic [ROW_W-1:0]     ram_rdata;
    logic [ROW_W-1:0]     row_upd;
    lookup_t              lk;
    logic                 take_in;
    logic                 look_done;

    slru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    slru_update #(
        .WAYS (WAYS)
    ) u_update (
        .row_rd (ram_rdata),
        .tag    (tag_reg),
        .row_wr (row_upd),
        .res    (lk)
    );

    assign access_stall = (state_reg != ST_IDLE);
    assign take_in      = access_valid && !access_stall;
    assign look_done    = (state_reg == ST_LOOK) && (!rv_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = byte_address[BLOCK_SHIFT +: SET_BITS];
        ram_wdata  = row_upd;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + SET_BITS'(1);
                if (clr_reg == SET_BITS'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (access_valid)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                ram_addr = set_reg;
                if (look_done)
                begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (look_done)
        begin
            if (lk.hit)
            begin
                hits_next = (hits_reg == '1) ? hits_reg : hits_reg + CNT_W'(1);
            end
            else
            begin
                misses_next = (misses_reg == '1) ? misses_reg : misses_reg + CNT_W'(1);
            end
        end
        if (look_done)
        begin
            rv_next = 1'b1;
        end
        else if (!result_stall)
        begin
            rv_next = 1'b0;
        end
        else
        begin
            rv_next = rv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            rv_reg     <= 1'b0;
            hits_reg   <= '0;
            misses_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            rv_reg     <= rv_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            set_reg <= byte_address[BLOCK_SHIFT +: SET_BITS];
            tag_reg <= byte_address[BLOCK_SHIFT + SET_BITS +: TAG_W];
        end
        if (look_done)
        begin
            hit_reg     <= lk.hit;
            evicted_reg <= lk.evicted;
            way_reg     <= lk.way[WAY_OUT_W-1:0];
        end
    end

    assign result_valid = rv_reg;
    assign hit          = hit_reg;
    assign way_used     = way_reg;
    assign evicted      = evicted_reg;
    assign hit_count    = hits_reg;
    assign miss_count   = misses_reg;

    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        take_in |=> (state_reg == ST_LOOK))
        else $error("accepted item did not start lookup");

    a_hits_move: assert property (@(posedge clk) disable iff (!rst_n)
        (hits_reg != $past(hits_reg)) || (misses_reg != $past(misses_reg))
            |-> $past(look_done))
        else $error("counter changed without a completed lookup");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(look_done))
        else $error("result raised without a completed lookup");

    a_no_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        look_done |-> !(lk.hit && lk.evicted))
        else $error("hit and eviction reported together");

endmodule

`default_nettype wire

/* bench/set_assoc_lru_cache_lookup_test.sv */
// Testbench for the set-associative LRU cache lookup: LRU predictor, scoreboard, random traffic.
`default_nettype none

module set_assoc_lru_cache_lookup_test;
    import slru_pkg::*;

    localparam int WAYS            = DEFAULT_WAYS;
    localparam int IDLE_LIMIT      = 10000;
    localparam int RANDOM_ACCESSES = 1850;
    localparam int HOT_SETS        = 8;
    localparam int HOT_TAGS        = 24;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        bit                 hit;
        bit [WAY_OUT_W-1:0] way;
        bit                 evicted;
        bit [CNT_W-1:0]     hits;
        bit [CNT_W-1:0]     misses;
    } lookup_result_t;

    class lru_scoreboard;
        bit [TAG_W-1:0] tag_mem [SETS][WAYS];
        bit             line_ok [SETS][WAYS];
        int unsigned    age     [SETS][WAYS];
        bit [CNT_W-1:0] hits;
        bit [CNT_W-1:0] misses;
        lookup_result_t outstanding[$];
        int             mismatches;

        function void note_access(bit [ADDR_W-1:0] addr);
            bit [SET_BITS-1:0] set_idx;
            bit [TAG_W-1:0]    tg;
            int unsigned       way;
            int unsigned       old_age;
            bit                found;
            lookup_result_t    res;
            set_idx = addr[BLOCK_SHIFT +: SET_BITS];
            tg      = addr[ADDR_W-1 -: TAG_W];
            res.hit     = 1'b0;
            res.evicted = 1'b0;
            way         = 0;
            for (int w = 0; w < WAYS; w++)
            begin
                if (!res.hit && line_ok[set_idx][w] && tag_mem[set_idx][w] == tg)
                begin
                    res.hit = 1'b1;
                    way     = w;
                end
            end
            if (res.hit)
            begin
                if (hits != '1)
                    hits++;
                old_age = age[set_idx][way];
            end
            else
            begin
                if (misses != '1)
                    misses++;
                found = 1'b0;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (!found && !line_ok[set_idx][w])
                    begin
                        found = 1'b1;
                        way   = w;
                    end
                end
                if (found)
                    old_age = WAYS;
                else
                begin
                    // full set: oldest way, lowest index on a tie
                    way = 0;
                    for (int w = 1; w < WAYS; w++)
                    begin
                        if (age[set_idx][w] > age[set_idx][way])
                            way = w;
                    end
                    res.evicted = 1'b1;
                    old_age     = age[set_idx][way];
                end
            end
            for (int k = 0; k < WAYS; k++)
            begin
                if (k != way && line_ok[set_idx][k] && age[set_idx][k] < old_age)
                    age[set_idx][k]++;
            end
            age[set_idx][way] = 0;
            if (!res.hit)
            begin
                tag_mem[set_idx][way] = tg;
                line_ok[set_idx][way] = 1'b1;
            end
            res.way    = way[WAY_OUT_W-1:0];
            res.hits   = hits;
            res.misses = misses;
            outstanding.push_back(res);
        endfunction

        function void check_result(bit h, bit [WAY_OUT_W-1:0] w, bit e,
                                   bit [CNT_W-1:0] hc, bit [CNT_W-1:0] mc);
            lookup_result_t exp_res;
            if (outstanding.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: hit=%0b way=%0d evicted=%0b",
                             h, w, e, " hits=%0d misses=%0d", hc, mc);
                return;
            end
            exp_res = outstanding.pop_front();
            if (h !== exp_res.hit || w !== exp_res.way || e !== exp_res.evicted ||
                hc !== exp_res.hits || mc !== exp_res.misses)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("mismatch: exp hit=%0b way=%0d evicted=%0b hits=%0d misses=%0d",
                             exp_res.hit, exp_res.way, exp_res.evicted, exp_res.hits,
                             exp_res.misses);
                    $display("          got hit=%0b way=%0d evicted=%0b hits=%0d misses=%0d",
                             h, w, e, hc, mc);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 access_valid = 1'b0;
    logic                 access_stall;
    logic [ADDR_W-1:0]    byte_address = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 evicted;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;

    lru_scoreboard sb = new();

    int burst_left = 0;
    int stall_left = 0;
    int free_left  = 0;
    int idle_cycles = 0;

    bit [SET_BITS-1:0] hot_set [HOT_SETS];
    bit [TAG_W-1:0]    hot_tag [HOT_TAGS];

    set_assoc_lru_cache_lookup #(
        .WAYS(WAYS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .access_valid (access_valid),
        .access_stall (access_stall),
        .byte_address (byte_address),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hit          (hit),
        .way_used     (way_used),
        .evicted      (evicted),
        .hit_count    (hit_count),
        .miss_count   (miss_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic drive_access(input bit [ADDR_W-1:0] addr);
        int gap;
        @(negedge clk);
        access_valid <= 1'b1;
        byte_address <= addr;
        do
            @(posedge clk);
        while (access_stall);
        sb.note_access(addr);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            @(negedge clk);
            access_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic access_block(input bit [TAG_W-1:0] tg, input bit [SET_BITS-1:0] set_idx,
                                input bit [BLOCK_SHIFT-1:0] offset);
        drive_access({tg, set_idx, offset});
    endtask

    // result stall pattern: stall runs between free runs
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            if (free_left > 0)
                free_left--;
            else
            begin
                stall_left = $urandom_range(0, 6);
                free_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                         : $urandom_range(0, 6);
            end
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(hit, way_used, evicted, hit_count, miss_count);
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((access_valid && !access_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        bit [63:0]             rnd;
        bit [ADDR_W-1:0]       addr;
        bit [BLOCK_SHIFT-1:0]  offset;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: address extremes, same-block hits, fill and evict in one set
        access_block('0, '0, '0);
        access_block('0, '0, '1);
        access_block('1, '1, '1);
        access_block('1, '1, '0);
        access_block('1, '0, '0);
        for (int t = 1; t <= WAYS + 1; t++)
            access_block(TAG_W'(t), SET_BITS'(5), t[BLOCK_SHIFT-1:0]);
        access_block(TAG_W'(2), SET_BITS'(5), '0);
        access_block(TAG_W'(1), SET_BITS'(5), '0);

        hot_set[0] = '0;
        hot_set[1] = '1;
        for (int i = 2; i < HOT_SETS; i++)
            hot_set[i] = SET_BITS'($urandom_range(0, SETS - 1));
        hot_tag[0] = '0;
        hot_tag[1] = '1;
        for (int i = 2; i < HOT_TAGS; i++)
            hot_tag[i] = TAG_W'($urandom());

        for (int n = 0; n < RANDOM_ACCESSES; n++)
        begin
            offset = BLOCK_SHIFT'($urandom());
            if ($urandom_range(0, 9) < 8)
                addr = {hot_tag[$urandom_range(0, HOT_TAGS - 1)],
                        hot_set[$urandom_range(0, HOT_SETS - 1)], offset};
            else
            begin
                rnd  = {$urandom(), $urandom()};
                addr = rnd[ADDR_W-1:0];
            end
            drive_access(addr);
        end
        @(negedge clk);
        access_valid <= 1'b0;

        while (sb.outstanding.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
